/* hw/rtl/psl_pkg.sv */
// Shared types and codes for the positional sequence list.
package psl_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int LEN_W        = 5;
  localparam int MODE_W       = 4;
  localparam int STAT_W       = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 4'd0,
    MODE_PUSH_BACK  = 4'd1,
    MODE_POP_FRONT  = 4'd2,
    MODE_POP_BACK   = 4'd3,
    MODE_INSERT     = 4'd4,
    MODE_REMOVE     = 4'd5,
    MODE_RETRIEVE   = 4'd6,
    MODE_REVERSE    = 4'd7,
    MODE_CLEAR      = 4'd8
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_RANGE = 3'd2,
    ST_FULL  = 3'd3,
    ST_SHORT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] length;
    logic             is_read;
  } result_t;

endpackage

/* hw/rtl/psl_cell.sv */
// One list entry: holds a word, takes a neighbor's word on a shift, drives a masked read.
module psl_cell
  import psl_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  at,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [DATA_W-1:0] next_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      OP_OPEN: begin
        if (MY_IDX > at) begin
          data_nxt = prev_data;
        end else if (MY_IDX == at) begin
          data_nxt = cmd.value;
        end
      end
      OP_CLOSE: begin
        if (MY_IDX >= at) begin
          data_nxt = next_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (MY_IDX == at) ? data_r : '0;

endmodule

/* hw/rtl/psl_ctrl.sv */
// Operation decode, status checks, entry count and orientation flag.
module psl_ctrl
  import psl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [MODE_W-1:0] mode,
  input  logic [DATA_W-1:0] value,
  input  logic [POS_W-1:0]  position,
  output cell_cmd_t         cmd,
  output logic [IDX_W-1:0]  at,
  output result_t           result,
  output logic [CNT_W-1:0]  count
);

  localparam int W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [W-1:0] CAP_W = W'(CAPACITY);
  localparam logic [W-1:0] ONE   = W'(1);
  localparam logic [W-1:0] TWO   = W'(2);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             rev_r;
  logic             rev_nxt;

  always_comb begin
    logic [W-1:0] n;
    logic [W-1:0] p;
    logic [W-1:0] phys;
    cell_op_t     op;
    status_t      st;
    logic         rd;

    n         = W'(count_r);
    p         = W'(position);
    phys      = '0;
    op        = OP_HOLD;
    st        = ST_OK;
    rd        = 1'b0;
    count_nxt = count_r;
    rev_nxt   = rev_r;

    unique case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (n >= CAP_W) begin
          st = ST_FULL;
        end else begin
          op        = OP_OPEN;
          phys      = ((mode == MODE_PUSH_FRONT) == rev_r) ? n : '0;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (n == '0) begin
          st = ST_EMPTY;
        end else begin
          op        = OP_CLOSE;
          phys      = ((mode == MODE_POP_FRONT) == rev_r) ? (n - ONE) : '0;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      MODE_INSERT: begin
        if (p < ONE || p > n + ONE) begin
          st = ST_RANGE;
        end else if (n >= CAP_W) begin
          st = ST_FULL;
        end else begin
          op        = OP_OPEN;
          phys      = rev_r ? (n - p + ONE) : (p - ONE);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      MODE_REMOVE, MODE_RETRIEVE: begin
        if (n == '0) begin
          st = ST_EMPTY;
        end else if (p < ONE || p > n) begin
          st = ST_RANGE;
        end else begin
          phys = rev_r ? (n - p) : (p - ONE);
          if (mode == MODE_REMOVE) begin
            op        = OP_CLOSE;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            rd = 1'b1;
          end
        end
      end
      MODE_REVERSE: begin
        if (n < TWO) begin
          st = ST_SHORT;
        end else begin
          rev_nxt = ~rev_r;
        end
      end
      MODE_CLEAR: begin
        count_nxt = '0;
        rev_nxt   = 1'b0;
      end
      default: begin
        st = ST_OK;
      end
    endcase

    cmd.op         = fire ? op : OP_HOLD;
    cmd.value      = value;
    at             = phys[IDX_W-1:0];
    result.status  = st;
    result.length  = LEN_W'(count_nxt);
    result.is_read = rd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (fire) begin
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  assign count = count_r;

endmodule

/* hw/rtl/positional_sequence_list.sv */
// Top level of the positional sequence list: a row of entry cells under one controller.
//
//  channel | dir | fields (lowest bit up)
//  --------+-----+-------------------------------------------------
//  in_     | in  | tuser: mode[3:0]; tdata: value[31:0], position[36:32], zero[39:37]
//  out_    | out | tdata: read_value[31:0], length[36:32], status[39:37]
//
// One operation per cycle unless the output stalls: every mode finishes in the cycle of
// its transfer, with the cells from the target slot up shifting toward or away from it
// at once; reverse flips an orientation flag instead of moving data. A retrieve picks
// its word through an OR over the masked cell outputs. Synchronous reset empties the list.
// A result waits in the output register; the input stalls only while it is held.
module positional_sequence_list
  import psl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // value[31:0], position[36:32], zero[39:37]
  input  logic [3:0]  in_tuser,  // mode[3:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata  // read_value[31:0], length[36:32], status[39:37]
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic              fire;
  cell_cmd_t         cmd;
  logic [IDX_W-1:0]  at;
  result_t           result;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_any;

  logic        out_valid_r;
  logic [39:0] out_data_r;
  logic [39:0] out_data_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  psl_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .mode     (in_tuser),
    .value    (in_tdata[31:0]),
    .position (in_tdata[36:32]),
    .cmd      (cmd),
    .at       (at),
    .result   (result),
    .count    (count)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_data[i+1];
    end
    psl_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .at        (at),
      .prev_data (prev_w),
      .next_data (next_w),
      .data      (cell_data[i]),
      .rd_data   (cell_rd[i])
    );
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  always_comb begin
    out_data_nxt[31:0]  = result.is_read ? rd_any : '0;
    out_data_nxt[36:32] = result.length;
    out_data_nxt[39:37] = result.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_tuser == MODE_CLEAR |=> count == '0)
    else $error("clear left entries");

  a_fail_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39:37] != ST_OK |-> out_tdata[31:0] == '0)
    else $error("failed operation returned data");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39:37] == ST_EMPTY |-> out_tdata[36:32] == '0)
    else $error("empty status with nonzero length");

endmodule
